[src/ddm_pkg.sv]
`default_nettype none

package ddm_pkg;

    // widths fixed by the item and register formats
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 12;
    localparam int unsigned DutyW     = 10;
    localparam int unsigned SpeedW    = 16;
    localparam int unsigned TargetW   = 14;

    // default full-scale duty
    localparam int unsigned DutyFullDefault = 1000;

    // stick value below which an axis counts as deflected low
    localparam logic [11:0] StickLow = 12'd20;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SPEED_GAIN,
        CFG_FOLLOW_SPEED,
        CFG_CENTER_X,
        CFG_DEAD_ZONE,
        CFG_STOP_DISTANCE,
        CFG_REMOTE_SPEED,
        CFG_REMOTE_TURN_DROP,
        CFG_STICK_HIGH
    } t_cfg_idx;

    // configuration reset values
    localparam logic [3:0]  SpeedGainReset      = 4'd3;
    localparam logic [9:0]  FollowSpeedReset    = 10'd200;
    localparam logic [10:0] CenterXReset        = 11'd320;
    localparam logic [9:0]  DeadZoneReset       = 10'd80;
    localparam logic [9:0]  StopDistanceReset   = 10'd15;
    localparam logic [9:0]  RemoteSpeedReset    = 10'd200;
    localparam logic [9:0]  RemoteTurnDropReset = 10'd75;
    localparam logic [11:0] StickHighReset      = 12'd4000;

    typedef enum logic [1:0] {
        MODE_STOP,
        MODE_CAMERA,
        MODE_REMOTE,
        MODE_HOLD
    } t_mode;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_FWD,
        DIR_REV
    } t_dir;

    typedef struct packed {
        logic [3:0]  speed_gain;
        logic [9:0]  follow_speed;
        logic [10:0] center_x;
        logic [9:0]  dead_zone;
        logic [9:0]  stop_distance;
        logic [9:0]  remote_speed;
        logic [9:0]  remote_turn_drop;
        logic [11:0] stick_high;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        drive_mode;
        logic              person_seen;
        logic [15:0]       obstacle_cm;
        logic [10:0]       target_x;
        logic [SpeedW-1:0] left_speed;
        logic [SpeedW-1:0] right_speed;
        logic [11:0]       stick_x;
        logic [11:0]       stick_y;
    } t_item;

    typedef struct packed {
        t_dir             left_dir;
        t_dir             right_dir;
        logic [DutyW-1:0] left_duty;
        logic [DutyW-1:0] right_duty;
    } t_res;

endpackage

`default_nettype wire

[src/ddm_in_if.sv]
`default_nettype none

interface ddm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  drive_mode;
    logic        person_seen;
    logic [15:0] obstacle_cm;
    logic [10:0] target_x;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [11:0] stick_x;
    logic [11:0] stick_y;

    modport source (
        output valid, drive_mode, person_seen, obstacle_cm, target_x,
               left_speed, right_speed, stick_x, stick_y,
        input  ready
    );

    modport sink (
        input  valid, drive_mode, person_seen, obstacle_cm, target_x,
               left_speed, right_speed, stick_x, stick_y,
        output ready
    );
endinterface

`default_nettype wire

[src/ddm_out_if.sv]
`default_nettype none

interface ddm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] left_dir;
    logic [1:0] right_dir;
    logic [9:0] left_duty;
    logic [9:0] right_duty;

    modport source (
        output valid, left_dir, right_dir, left_duty, right_duty,
        input  ready
    );

    modport sink (
        input  valid, left_dir, right_dir, left_duty, right_duty,
        output ready
    );
endinterface

`default_nettype wire

[src/ddm_cfg.sv]
`default_nettype none

module ddm_cfg
    import ddm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_we,
    input  wire logic [CfgIdxW-1:0]  i_idx,
    input  wire logic [CfgDataW-1:0] i_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    // register file, each write masked to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_gain       <= SpeedGainReset;
            r_cfg.follow_speed     <= FollowSpeedReset;
            r_cfg.center_x         <= CenterXReset;
            r_cfg.dead_zone        <= DeadZoneReset;
            r_cfg.stop_distance    <= StopDistanceReset;
            r_cfg.remote_speed     <= RemoteSpeedReset;
            r_cfg.remote_turn_drop <= RemoteTurnDropReset;
            r_cfg.stick_high       <= StickHighReset;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_SPEED_GAIN:       r_cfg.speed_gain       <= i_data[3:0];
                CFG_FOLLOW_SPEED:     r_cfg.follow_speed     <= i_data[9:0];
                CFG_CENTER_X:         r_cfg.center_x         <= i_data[10:0];
                CFG_DEAD_ZONE:        r_cfg.dead_zone        <= i_data[9:0];
                CFG_STOP_DISTANCE:    r_cfg.stop_distance    <= i_data[9:0];
                CFG_REMOTE_SPEED:     r_cfg.remote_speed     <= i_data[9:0];
                CFG_REMOTE_TURN_DROP: r_cfg.remote_turn_drop <= i_data[9:0];
                CFG_STICK_HIGH:       r_cfg.stick_high       <= i_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/ddm_duty.sv]
`default_nettype none

module ddm_duty
    import ddm_pkg::*;
#(
    parameter int unsigned DUTY_FULL = DutyFullDefault
) (
    input  wire logic signed [TargetW-1:0] i_target,
    input  wire logic        [SpeedW-1:0]  i_actual,
    input  wire logic        [3:0]         i_gain,
    output logic             [DutyW-1:0]   o_duty
);

    localparam int unsigned ErrW  = SpeedW + 2;
    localparam int unsigned PosW  = ErrW - 1;
    localparam int unsigned ProdW = PosW + 4;
    localparam logic [ProdW-1:0] DutyFullP = ProdW'(DUTY_FULL);

    logic signed [ErrW-1:0] err;
    logic        [PosW-1:0] err_pos;
    logic        [ProdW-1:0] prod;

    // speed error, negative part dropped
    assign err = $signed({{(ErrW-TargetW){i_target[TargetW-1]}}, i_target})
               - $signed({2'b00, i_actual});
    assign err_pos = err[ErrW-1] ? '0 : err[PosW-1:0];

    // proportional term, saturated to full scale
    assign prod   = {4'b0000, err_pos} * {{PosW{1'b0}}, i_gain};
    assign o_duty = (prod > DutyFullP) ? DutyFullP[DutyW-1:0] : prod[DutyW-1:0];

endmodule

`default_nettype wire

[src/ddm_mix.sv]
`default_nettype none

module ddm_mix
    import ddm_pkg::*;
#(
    parameter int unsigned DUTY_FULL = DutyFullDefault
) (
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    input  wire t_res  i_state,
    output t_res       o_next
);

    typedef enum logic [1:0] {
        AXIS_MID,
        AXIS_LOW,
        AXIS_HIGH
    } t_axis;

    logic signed [11:0]        off;
    logic        [10:0]        abs_off;
    logic                      near;
    logic                      cam_stop;
    logic signed [TargetW-1:0] fs_t;
    logic signed [TargetW-1:0] off_t;
    logic signed [TargetW-1:0] dz_t;
    logic signed [TargetW-1:0] rsp_t;
    logic signed [TargetW-1:0] drop_t;
    logic signed [TargetW-1:0] cam_tl;
    logic signed [TargetW-1:0] cam_tr;
    logic signed [TargetW-1:0] rem_tl;
    logic signed [TargetW-1:0] rem_tr;
    logic signed [TargetW-1:0] tgt_l;
    logic signed [TargetW-1:0] tgt_r;
    t_axis                     xa;
    t_axis                     ya;
    t_dir                      rem_ldir;
    t_dir                      rem_rdir;
    logic        [DutyW-1:0]   duty_l;
    logic        [DutyW-1:0]   duty_r;
    t_mode                     mode;

    assign mode = t_mode'(i_item.drive_mode);

    // camera: offset from center, dead zone and stop test
    assign off      = $signed({1'b0, i_item.target_x}) - $signed({1'b0, i_cfg.center_x});
    assign abs_off  = off[11] ? 11'(-off) : off[10:0];
    assign near     = abs_off < {1'b0, i_cfg.dead_zone};
    assign cam_stop = !i_item.person_seen || (i_item.obstacle_cm < {6'b0, i_cfg.stop_distance});

    assign fs_t   = $signed({4'b0000, i_cfg.follow_speed});
    assign off_t  = $signed({{2{off[11]}}, off});
    assign dz_t   = $signed({4'b0000, i_cfg.dead_zone});
    assign cam_tl = (near || !off[11]) ? fs_t : fs_t + off_t + dz_t;
    assign cam_tr = (near || off[11])  ? fs_t : fs_t - off_t + dz_t;

    // remote: classify each stick axis, high tested first
    always_comb begin
        if (i_item.stick_x > i_cfg.stick_high) begin
            xa = AXIS_HIGH;
        end else if (i_item.stick_x < StickLow) begin
            xa = AXIS_LOW;
        end else begin
            xa = AXIS_MID;
        end
        if (i_item.stick_y > i_cfg.stick_high) begin
            ya = AXIS_HIGH;
        end else if (i_item.stick_y < StickLow) begin
            ya = AXIS_LOW;
        end else begin
            ya = AXIS_MID;
        end
    end

    assign rsp_t  = $signed({4'b0000, i_cfg.remote_speed});
    assign drop_t = $signed({4'b0000, i_cfg.remote_turn_drop});
    assign rem_tl = (xa == AXIS_LOW  && ya != AXIS_MID) ? rsp_t - drop_t : rsp_t;
    assign rem_tr = (xa == AXIS_HIGH && ya != AXIS_MID) ? rsp_t - drop_t : rsp_t;

    // remote directions: stick y sets travel, x alone spins
    always_comb begin
        rem_ldir = i_state.left_dir;
        rem_rdir = i_state.right_dir;
        if (ya == AXIS_LOW) begin
            rem_ldir = DIR_FWD;
            rem_rdir = DIR_FWD;
        end else if (ya == AXIS_HIGH) begin
            rem_ldir = DIR_REV;
            rem_rdir = DIR_REV;
        end else if (xa == AXIS_LOW) begin
            rem_ldir = DIR_REV;
            rem_rdir = DIR_FWD;
        end else if (xa == AXIS_HIGH) begin
            rem_ldir = DIR_FWD;
            rem_rdir = DIR_REV;
        end
    end

    // shared duty units
    assign tgt_l = (mode == MODE_REMOTE) ? rem_tl : cam_tl;
    assign tgt_r = (mode == MODE_REMOTE) ? rem_tr : cam_tr;

    ddm_duty #(.DUTY_FULL(DUTY_FULL)) u_duty_l (
        .i_target (tgt_l),
        .i_actual (i_item.left_speed),
        .i_gain   (i_cfg.speed_gain),
        .o_duty   (duty_l)
    );

    ddm_duty #(.DUTY_FULL(DUTY_FULL)) u_duty_r (
        .i_target (tgt_r),
        .i_actual (i_item.right_speed),
        .i_gain   (i_cfg.speed_gain),
        .o_duty   (duty_r)
    );

    // next state by drive mode
    always_comb begin
        o_next = i_state;
        case (mode)
            MODE_STOP: begin
                o_next.left_duty  = '0;
                o_next.right_duty = '0;
            end
            MODE_CAMERA: begin
                o_next.left_dir   = DIR_FWD;
                o_next.right_dir  = DIR_FWD;
                o_next.left_duty  = cam_stop ? '0 : duty_l;
                o_next.right_duty = cam_stop ? '0 : duty_r;
            end
            MODE_REMOTE: begin
                o_next.left_dir  = rem_ldir;
                o_next.right_dir = rem_rdir;
                if (xa == AXIS_MID && ya == AXIS_MID) begin
                    o_next.left_duty  = '0;
                    o_next.right_duty = '0;
                end else begin
                    o_next.left_duty  = duty_l;
                    o_next.right_duty = duty_r;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[src/differential_drive_mixer_top.sv]
// channel   dir   handshake      payload
// i_in      in    valid/ready    drive_mode, person_seen, obstacle_cm, target_x,
//                                left_speed, right_speed, stick_x, stick_y
// o_out     out   valid/ready    left_dir, right_dir, left_duty, right_duty
// i_cfg_*   in    write enable   i_cfg_idx register index, i_cfg_data value
//
// one item per cycle sustained while o_out is not stalled; an accepted item passes
// the input register, then the result register, before it is shown on o_out
// the result register also holds the drive state that the next item starts from
// synchronous active-low reset clears both stages, the drive state and the
// configuration registers to their defaults
// a stalled output holds the result; the input register still takes one more
// item before i_in.ready drops
`default_nettype none

module differential_drive_mixer_top
    import ddm_pkg::*;
#(
    parameter int unsigned DUTY_FULL = DutyFullDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    ddm_in_if.sink                   i_in,
    ddm_out_if.source                o_out
);

    t_cfg  cfg;
    t_item in_item;
    t_item r_item;
    t_res  r_res;
    t_res  n_res;
    logic  r_s1_valid;
    logic  r_s2_valid;
    logic  s2_free;
    logic  advance;
    logic  take;

    ddm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // pack the incoming item
    assign in_item.drive_mode  = i_in.drive_mode;
    assign in_item.person_seen = i_in.person_seen;
    assign in_item.obstacle_cm = i_in.obstacle_cm;
    assign in_item.target_x    = i_in.target_x;
    assign in_item.left_speed  = i_in.left_speed;
    assign in_item.right_speed = i_in.right_speed;
    assign in_item.stick_x     = i_in.stick_x;
    assign in_item.stick_y     = i_in.stick_y;

    // stage handshake
    assign s2_free    = !r_s2_valid || o_out.ready;
    assign advance    = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign take       = i_in.valid && i_in.ready;

    ddm_mix #(.DUTY_FULL(DUTY_FULL)) u_mix (
        .i_item  (r_item),
        .i_cfg   (cfg),
        .i_state (r_res),
        .o_next  (n_res)
    );

    // input register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= in_item;
        end
    end

    // stage valids and drive state / result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_res      <= '{left_dir: DIR_NONE, right_dir: DIR_NONE,
                            left_duty: '0, right_duty: '0};
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_s2_valid <= 1'b1;
                r_res      <= n_res;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // result channel
    assign o_out.valid      = r_s2_valid;
    assign o_out.left_dir   = r_res.left_dir;
    assign o_out.right_dir  = r_res.right_dir;
    assign o_out.left_duty  = r_res.left_duty;
    assign o_out.right_duty = r_res.right_duty;

endmodule

`default_nettype wire

[src/ddm_check.sv]
`default_nettype none

module ddm_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_left_dir,
    input wire logic [1:0] i_right_dir
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // direction codes stay within not set, forward, reverse
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left_dir != 2'd3) && (i_right_dir != 2'd3))
        else $error("illegal direction code");

    // a fresh result follows an accepted item, via the input and result registers
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without an accepted item");

endmodule

bind differential_drive_mixer_top ddm_check u_ddm_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left_dir  (o_out.left_dir),
    .i_right_dir (o_out.right_dir)
);

`default_nettype wire
